// ----- rtl/core/urlpc_pkg.sv -----
// Shared types, character constants and character-class functions for the
// URL percent codec. Used by every module in rtl/core but the checker; depends on nothing.
`default_nettype none

package urlpc_pkg;

   localparam int unsigned MAX_BEATS = 3;
   localparam int unsigned BEAT_IDX_W = 2;

   localparam logic [7:0] PERCENT_CHAR = 8'h25;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // One classified input: up to three output bytes, first byte in slot 0.
   typedef struct packed {
      logic [MAX_BEATS-1:0][7:0] data;
      logic [BEAT_IDX_W-1:0]     count;
      logic                      text_end;
   } job_type;

   function automatic logic is_reserved(input logic [7:0] c);
      logic hit;
      unique case (c)
         8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
         8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B,
         8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D: hit = 1'b1;
         default:                           hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Uppercase ASCII hex digit for a nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] ch;
      if (nibble < 4'd10) begin
         ch = 8'h30 + {4'h0, nibble};
      end else begin
         ch = 8'h37 + {4'h0, nibble};
      end
      return ch;
   endfunction

   // Bit 4 set means the byte is not an uppercase hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b0, c[3:0] + 4'd9};
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/urlpc_front.sv -----
// Front end of the URL percent codec: takes input beats, tracks the decode
// phase and turns each beat into a job of zero to three bytes. Uses urlpc_pkg.
`default_nettype none

module urlpc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_wr_data,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [7:0]       req_text_byte,
   input  wire logic             req_text_end,
   output logic                  push_valid,
   input  wire logic             push_ready,
   output urlpc_pkg::job_type    push_job
);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       direction_ff;
   logic [7:0] held_ff, held_in;
   logic       accept;
   logic [4:0] hi_val, lo_val;
   logic [7:0] decoded;

   assign hi_val  = urlpc_pkg::hex_value(held_ff);
   assign lo_val  = urlpc_pkg::hex_value(req_text_byte);
   assign decoded = {hi_val[3:0], lo_val[3:0]};

   always_comb begin
      push_job          = '0;
      push_job.text_end = req_text_end;
      phase_in          = phase_ff;
      held_in           = held_ff;
      if (direction_ff == urlpc_pkg::DIR_ENCODE) begin
         if (urlpc_pkg::is_reserved(req_text_byte)) begin
            push_job.data[0] = urlpc_pkg::PERCENT_CHAR;
            push_job.data[1] = urlpc_pkg::hex_char(req_text_byte[7:4]);
            push_job.data[2] = urlpc_pkg::hex_char(req_text_byte[3:0]);
            push_job.count   = 2'd3;
         end else begin
            push_job.data[0] = req_text_byte;
            push_job.count   = 2'd1;
         end
      end else begin
         unique case (phase_ff)
            PH_PCT: begin
               if (req_text_end) begin
                  push_job.data[0] = urlpc_pkg::PERCENT_CHAR;
                  push_job.data[1] = req_text_byte;
                  push_job.count   = 2'd2;
                  phase_in         = PH_IDLE;
               end else begin
                  held_in  = req_text_byte;
                  phase_in = PH_DIGIT;
               end
            end
            PH_DIGIT: begin
               if (!hi_val[4] && !lo_val[4] && urlpc_pkg::is_reserved(decoded)) begin
                  push_job.data[0] = decoded;
                  push_job.count   = 2'd1;
               end else begin
                  push_job.data[0] = urlpc_pkg::PERCENT_CHAR;
                  push_job.data[1] = held_ff;
                  push_job.data[2] = req_text_byte;
                  push_job.count   = 2'd3;
               end
               phase_in = PH_IDLE;
            end
            default: begin
               if (req_text_byte == urlpc_pkg::PERCENT_CHAR && !req_text_end) begin
                  phase_in = PH_PCT;
               end else begin
                  push_job.data[0] = req_text_byte;
                  push_job.count   = 2'd1;
                  phase_in         = PH_IDLE;
               end
            end
         endcase
      end
   end

   // A beat that only gets held produces no job and needs no queue slot,
   // but is still gated by queue space to keep ready simple.
   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = req_valid && (push_job.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= urlpc_pkg::DIR_ENCODE;
         phase_ff     <= PH_IDLE;
         held_ff      <= '0;
      end else if (csr_wr_en) begin
         direction_ff <= csr_wr_data;
         phase_ff     <= PH_IDLE;
         held_ff      <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/urlpc_fifo.sv -----
// Small job queue between the front and back ends of the URL percent codec.
// Uses urlpc_pkg for the job type.
`default_nettype none

module urlpc_fifo #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire urlpc_pkg::job_type push_job,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output urlpc_pkg::job_type      pop_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   urlpc_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/urlpc_back.sv -----
// Back end of the URL percent codec: holds one job in its output register
// and sends its bytes as result beats. Uses urlpc_pkg for the job type.
`default_nettype none

module urlpc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   output logic                     pop_ready,
   input  wire urlpc_pkg::job_type  pop_job,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_out_last,
   output logic                     rsp_out_text_end
);

   urlpc_pkg::job_type                 job_ff;
   logic                               valid_ff;
   logic [urlpc_pkg::BEAT_IDX_W-1:0]   idx_ff;
   logic                               is_last, take;

   assign is_last          = (idx_ff == job_ff.count - 1'b1);
   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = job_ff.data[idx_ff];
   assign rsp_out_last     = is_last;
   assign rsp_out_text_end = is_last && job_ff.text_end;

   // Load the next job when empty or when the last byte leaves this cycle.
   assign take      = !valid_ff || (rsp_ready && is_last);
   assign pop_ready = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (take) begin
         valid_ff <= pop_valid;
         idx_ff   <= '0;
      end else if (rsp_ready) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take && pop_valid) begin
         job_ff <= pop_job;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/url_percent_codec.sv -----
// Top level of the URL percent codec: front end, job queue and back end.
// Depends on urlpc_pkg, urlpc_front, urlpc_fifo and urlpc_back.
//
// Usage:
//   Text enters one byte per beat on the req_ channel (valid/ready), with
//   req_text_end set on the final byte of a text. Converted bytes leave one
//   per beat on the rsp_ channel; rsp_out_last marks the final byte caused
//   by an input beat and rsp_out_text_end the final byte of the whole text.
//   csr_wr_en with csr_wr_data selects the direction (0 encodes reserved
//   characters as %XX, 1 decodes uppercase %XX codes of reserved characters)
//   and drops any partly received triple. Write it only while the block is idle.
//
// Timing:
//   A beat's job enters the job queue when the beat is accepted and then
//   moves into the output register, from which its first result byte is
//   offered on rsp_. One input beat is taken per cycle while each beat
//   yields at most one byte and the receiver is ready; a three-byte
//   expansion holds the output register until its last byte has left, so
//   the output byte count sets the rate. Beats that are only held ('%' and
//   its first digit) make no job but still need a free queue slot to be taken.
//
// Reset and stalls:
//   Reset (synchronous, active high) selects encoding, empties the job queue
//   and the output register. When the receiver stalls, the current byte
//   holds, the queue of QUEUE_DEPTH jobs fills and req_ready then drops.
`default_nettype none

module url_percent_codec #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_text_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_last,
   output logic             rsp_out_text_end
);

   urlpc_pkg::job_type push_job, pop_job;
   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;

   urlpc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .req_text_end  (req_text_end),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_job      (push_job)
   );

   urlpc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   urlpc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_job          (pop_job),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_out_text_end (rsp_out_text_end)
   );

endmodule

`default_nettype wire

// ----- rtl/core/urlpc_checker.sv -----
// Port-level checks for the URL percent codec, bound to the top level.
// Depends only on the ports of url_percent_codec.
`default_nettype none

module urlpc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_last,
   input wire logic       rsp_out_text_end
);

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_last) && $stable(rsp_out_text_end))
      else $error("stalled result beat changed");

   // The end of the text can only fall on the last byte of an input beat.
   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_text_end |-> rsp_out_last)
      else $error("text end flagged on a byte that is not last");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Reset empties the job queue, so input is taken right away.
   a_reset_ready: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("input not ready right after reset");

endmodule

bind url_percent_codec urlpc_checker u_urlpc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_out_last     (rsp_out_last),
   .rsp_out_text_end (rsp_out_text_end)
);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for url_percent_codec: a directed table followed by
// randomized encode and decode traffic under several idle and stall mixes.
// Depends on urlpc_pkg and the url_percent_codec RTL.

module tb;

   // Clock period is 20 ns; the whole run is bounded by a cycle budget that
   // is many times the slowest legal run (about 350 beats, three result beats
   // each, every result beat waiting out heavy receiver stalls).
   localparam int unsigned CYCLE_LIMIT  = 400000;
   // A result passes through the job queue and the output register before it can be
   // taken; wait a little longer than that before a direction write so a held '%' is surely settled.
   localparam int unsigned SETTLE_TICKS = 6;
   // Long receiver hold-off used to fill the job queue and stall req_ready.
   localparam int unsigned HOLD_TICKS   = 80;

   // The 21 reserved characters, space through ']'.
   localparam logic [0:20][7:0] RESERVED_SET = {
      8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A,
      8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D};
   localparam logic [0:15][7:0] HEX_UPPER  = "0123456789ABCDEF";
   // Digits used to build triples that are well formed in shape but may
   // carry lowercase letters or codes of unreserved characters.
   localparam logic [0:21][7:0] DIGIT_POOL = "0123456789ABCDEFabcdef";

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PERCENT,
      PH_DIGIT
   } decode_phase_type;

   typedef enum logic {
      ROW_BEAT,
      ROW_DIR
   } row_kind_type;

   // One row of the directed table. When typed is set, the expected bytes
   // are written out here (first byte leftmost); otherwise the predictor
   // supplies them.
   typedef struct packed {
      row_kind_type    kind;
      logic [7:0]      data;
      logic            text_end;
      logic            typed;
      logic [1:0]      n_exp;
      logic [0:2][7:0] exp_bytes;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       text_end;
   } out_beat_type;

   typedef struct packed {
      logic [7:0] data;
      logic       text_end;
   } text_beat_type;

   typedef struct packed {
      logic       dir;
      logic [7:0] idle_pct;
      logic [7:0] stall_pct;
      logic [8:0] beats;
      logic       squeeze;
   } traffic_phase_type;

   localparam stim_row_type DIRECTED_ROWS [30] = '{
      // Encoding straight out of reset: pass-through and byte extremes.
      '{ROW_BEAT, 8'h41, 1'b0, 1'b1, 2'd1, 24'h410000},
      '{ROW_BEAT, 8'h00, 1'b0, 1'b1, 2'd1, 24'h000000},
      '{ROW_BEAT, 8'hFF, 1'b0, 1'b1, 2'd1, 24'hFF0000},
      // Reserved characters expand; the last one also closes the text.
      '{ROW_BEAT, 8'h5D, 1'b0, 1'b1, 2'd3, 24'h253544},
      '{ROW_BEAT, 8'h25, 1'b1, 1'b1, 2'd3, 24'h253235},
      '{ROW_DIR,  {7'd0, urlpc_pkg::DIR_DECODE}, 1'b0, 1'b0, 2'd0, 24'h0},
      // A known uppercase code decodes to one byte.
      '{ROW_BEAT, 8'h25, 1'b0, 1'b1, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h32, 1'b0, 1'b1, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h46, 1'b0, 1'b1, 2'd1, 24'h2F0000},
      // Lowercase hex is not a known code and comes out raw.
      '{ROW_BEAT, 8'h25, 1'b0, 1'b1, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h32, 1'b0, 1'b1, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h66, 1'b0, 1'b1, 2'd3, 24'h253266},
      // A rejected triple of percent signs does not reopen a triple.
      '{ROW_BEAT, 8'h25, 1'b0, 1'b1, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h25, 1'b0, 1'b1, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h25, 1'b0, 1'b1, 2'd3, 24'h252525},
      // A lone '%' that ends the text passes straight through.
      '{ROW_BEAT, 8'h25, 1'b1, 1'b1, 2'd1, 24'h250000},
      // Text ends with '%' and one digit held: both are flushed raw.
      '{ROW_BEAT, 8'h25, 1'b0, 1'b1, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h35, 1'b1, 1'b1, 2'd2, 24'h253500},
      // A complete triple on the final byte still decodes.
      '{ROW_BEAT, 8'h25, 1'b0, 1'b1, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h35, 1'b0, 1'b1, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h44, 1'b1, 1'b1, 2'd1, 24'h5D0000},
      // Held bytes are dropped by a direction write.
      '{ROW_BEAT, 8'h25, 1'b0, 1'b1, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h32, 1'b0, 1'b1, 2'd0, 24'h0},
      '{ROW_DIR,  {7'd0, urlpc_pkg::DIR_DECODE}, 1'b0, 1'b0, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h30, 1'b0, 1'b1, 2'd1, 24'h300000},
      // Valid hex of an unreserved character stays encoded.
      '{ROW_BEAT, 8'h25, 1'b0, 1'b0, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h34, 1'b0, 1'b0, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h31, 1'b1, 1'b0, 2'd0, 24'h0},
      '{ROW_DIR,  {7'd0, urlpc_pkg::DIR_ENCODE}, 1'b0, 1'b0, 2'd0, 24'h0},
      '{ROW_BEAT, 8'h3F, 1'b1, 1'b1, 2'd3, 24'h253346}
   };

   // Random phases: no idling, sender idle, receiver stalling, both, and a
   // final one where the receiver holds off for a long stretch.
   localparam traffic_phase_type TRAFFIC_PHASES [6] = '{
      '{urlpc_pkg::DIR_ENCODE, 8'd0,  8'd0,  9'd45, 1'b0},
      '{urlpc_pkg::DIR_DECODE, 8'd68, 8'd0,  9'd55, 1'b0},
      '{urlpc_pkg::DIR_DECODE, 8'd0,  8'd68, 9'd55, 1'b0},
      '{urlpc_pkg::DIR_ENCODE, 8'd38, 8'd38, 9'd50, 1'b0},
      '{urlpc_pkg::DIR_DECODE, 8'd38, 8'd38, 9'd60, 1'b0},
      '{urlpc_pkg::DIR_DECODE, 8'd0,  8'd0,  9'd55, 1'b1}
   };

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       csr_wr_en         = 1'b0;
   logic       csr_wr_data       = 1'b0;
   logic       req_valid         = 1'b0;
   logic [7:0] req_text_byte     = 8'h00;
   logic       req_text_end      = 1'b0;
   logic       rsp_ready         = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       rsp_out_text_end;

   // Predictor state, kept in step with the block at every accepted beat
   // and every direction write.
   logic             pred_dir   = urlpc_pkg::DIR_ENCODE;
   decode_phase_type pred_phase = PH_IDLE;
   logic [7:0]       pred_held  = 8'h00;

   out_beat_type  expected_beats [$];
   text_beat_type pending_text [$];

   int unsigned  sender_idle_pct    = 0;
   int unsigned  receiver_stall_pct = 0;
   bit           hold_request       = 1'b0;
   int unsigned  hold_left          = 0;
   int unsigned  mismatches         = 0;
   int unsigned  cycle_count        = 0;
   out_beat_type oldest;

   url_percent_codec i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_text_end     (req_text_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_out_text_end (rsp_out_text_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic is_url_reserved(input logic [7:0] c);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < 21; k++) begin
         if (RESERVED_SET[k] == c) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   // Value of an uppercase hex digit; bit 4 set flags anything else.
   function automatic logic [4:0] ascii_to_nibble(input logic [7:0] c);
      logic [4:0] v;
      if (c >= "0" && c <= "9") begin
         v = 5'(c - "0");
      end else if (c >= "A" && c <= "F") begin
         v = 5'(c - "A" + 8'd10);
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

   // Converts one accepted text byte, advancing the predictor state, and
   // returns how many output bytes it causes (first byte in slot 0).
   function automatic int unsigned convert_byte(input logic [7:0] b, input logic last_in_text,
                                                output logic [0:2][7:0] o);
      int unsigned n;
      logic [4:0]  hi;
      logic [4:0]  lo;
      logic [7:0]  code;
      n = 0;
      o = '0;
      if (pred_dir == urlpc_pkg::DIR_ENCODE) begin
         if (is_url_reserved(b)) begin
            o = {urlpc_pkg::PERCENT_CHAR, HEX_UPPER[b[7:4]], HEX_UPPER[b[3:0]]};
            n = 3;
         end else begin
            o[0] = b;
            n = 1;
         end
      end else begin
         unique case (pred_phase)
            PH_PERCENT: begin
               if (last_in_text) begin
                  o[0] = urlpc_pkg::PERCENT_CHAR;
                  o[1] = b;
                  n = 2;
                  pred_phase = PH_IDLE;
               end else begin
                  pred_held = b;
                  pred_phase = PH_DIGIT;
               end
            end
            PH_DIGIT: begin
               hi = ascii_to_nibble(pred_held);
               lo = ascii_to_nibble(b);
               code = {hi[3:0], lo[3:0]};
               if (!hi[4] && !lo[4] && is_url_reserved(code)) begin
                  o[0] = code;
                  n = 1;
               end else begin
                  o = {urlpc_pkg::PERCENT_CHAR, pred_held, b};
                  n = 3;
               end
               pred_phase = PH_IDLE;
            end
            default: begin
               if (b == urlpc_pkg::PERCENT_CHAR && !last_in_text) begin
                  pred_phase = PH_PERCENT;
               end else begin
                  o[0] = b;
                  n = 1;
                  pred_phase = PH_IDLE;
               end
            end
         endcase
      end
      return n;
   endfunction

   // Offers one beat, holding it until accepted, then queues what it should
   // produce. Random idle cycles come first, with noise on the payload.
   task automatic send_text_byte(input logic [7:0] b, input logic last_in_text,
                                 input logic typed, input logic [1:0] typed_n,
                                 input logic [0:2][7:0] typed_bytes);
      logic [0:2][7:0] predicted;
      int unsigned     n;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         req_text_byte <= 8'($urandom);
         req_text_end <= 1'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_text_end <= last_in_text;
      do begin
         @(posedge clock);
      end while (!req_ready);
      // The predictor always runs so its state follows the block; a typed
      // row only replaces the bytes it would have produced.
      n = convert_byte(b, last_in_text, predicted);
      if (typed) begin
         n = {30'd0, typed_n};
         predicted = typed_bytes;
      end
      for (int k = 0; k < n; k++) begin
         expected_beats.push_back('{predicted[k], k == n - 1, last_in_text && k == n - 1});
      end
   endtask

   // Direction writes happen only with the block drained: no result pending,
   // and a few more cycles so that a beat that caused no result has settled.
   task automatic write_direction(input logic dir);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_TICKS) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= dir;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      csr_wr_data <= 1'($urandom);
      pred_dir = dir;
      pred_phase = PH_IDLE;
      pred_held = 8'h00;
   endtask

   // Appends a short piece of random text to the pending queue. In decode
   // mode half the pieces are well-formed triples of reserved codes, so the
   // decoder spends its time past the first states; the rest are near-miss
   // triples, broken triples, truncated endings and plain noise.
   task automatic queue_random_text();
      logic [7:0]  c;
      int unsigned pick;
      int unsigned run;
      pick = $urandom_range(99);
      if (pred_dir == urlpc_pkg::DIR_ENCODE) begin
         c = (pick < 50) ? RESERVED_SET[$urandom_range(20)] : 8'($urandom_range(255));
         pending_text.push_back('{c, $urandom_range(15) == 0});
      end else if (pick < 50) begin
         c = RESERVED_SET[$urandom_range(20)];
         pending_text.push_back('{urlpc_pkg::PERCENT_CHAR, $urandom_range(19) == 0});
         pending_text.push_back('{HEX_UPPER[c[7:4]], $urandom_range(19) == 0});
         pending_text.push_back('{HEX_UPPER[c[3:0]], $urandom_range(19) == 0});
      end else if (pick < 65) begin
         pending_text.push_back('{urlpc_pkg::PERCENT_CHAR, 1'b0});
         pending_text.push_back('{DIGIT_POOL[$urandom_range(21)], 1'b0});
         pending_text.push_back('{DIGIT_POOL[$urandom_range(21)], $urandom_range(9) == 0});
      end else if (pick < 75) begin
         pending_text.push_back('{urlpc_pkg::PERCENT_CHAR, 1'b0});
         pending_text.push_back('{8'($urandom_range(255)), 1'b0});
         pending_text.push_back('{8'($urandom_range(255)), $urandom_range(9) == 0});
      end else if (pick < 85) begin
         // Text that stops partway into a triple.
         if ($urandom_range(1) == 0) begin
            pending_text.push_back('{urlpc_pkg::PERCENT_CHAR, 1'b0});
         end
         pending_text.push_back('{$urandom_range(1) ? urlpc_pkg::PERCENT_CHAR
                                  : DIGIT_POOL[$urandom_range(21)], 1'b1});
      end else begin
         run = $urandom_range(4, 1);
         for (int k = 0; k < run; k++) begin
            pending_text.push_back('{8'($urandom_range(255)), $urandom_range(19) == 0});
         end
      end
   endtask

   // Receiver: random stalls at the phase's rate, or a long hold-off on
   // request so the job queue fills and the block stops taking input.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_TICKS;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Result checker: every accepted result beat is matched against the
   // oldest expected beat, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result beat: byte %h last %b text_end %b",
                        rsp_out_byte, rsp_out_last, rsp_out_text_end);
            end
         end else begin
            oldest = expected_beats.pop_front();
            if (rsp_out_byte !== oldest.data || rsp_out_last !== oldest.last
                || rsp_out_text_end !== oldest.text_end) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result mismatch: expected byte %h last %b text_end %b,",
                           oldest.data, oldest.last, oldest.text_end,
                           " got byte %h last %b text_end %b",
                           rsp_out_byte, rsp_out_last, rsp_out_text_end);
               end
            end
         end
      end
   end

   // Watchdog for a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      text_beat_type     next_beat;
      traffic_phase_type ph;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table, with no idling on either side.
      foreach (DIRECTED_ROWS[r]) begin
         if (DIRECTED_ROWS[r].kind == ROW_DIR) begin
            write_direction(DIRECTED_ROWS[r].data[0]);
         end else begin
            send_text_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].text_end,
                           DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].n_exp,
                           DIRECTED_ROWS[r].exp_bytes);
         end
      end

      // Random traffic. Each phase starts from a drained block with a fresh
      // direction write; leftover partial text from the last phase is dropped.
      foreach (TRAFFIC_PHASES[p]) begin
         ph = TRAFFIC_PHASES[p];
         write_direction(ph.dir);
         sender_idle_pct = ph.idle_pct;
         receiver_stall_pct = ph.stall_pct;
         pending_text.delete();
         if (ph.squeeze) begin
            hold_request = 1'b1;
         end
         for (int unsigned k = 0; k < ph.beats; k++) begin
            if (pending_text.size() == 0) begin
               queue_random_text();
            end
            next_beat = pending_text.pop_front();
            send_text_byte(next_beat.data, next_beat.text_end, 1'b0, 2'd0, '0);
         end
      end

      // Drain: wait for every expected beat, then a few cycles so a stray
      // extra beat would still be caught.
      @(negedge clock);
      req_valid <= 1'b0;
      receiver_stall_pct = 0;
      while (expected_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/urlpc_pkg.sv
rtl/core/urlpc_front.sv
rtl/core/urlpc_fifo.sv
rtl/core/urlpc_back.sv
rtl/core/url_percent_codec.sv
rtl/core/urlpc_checker.sv
dv/tb.sv
